[sv/dotted_line_rasterizer_core_assert.svh]
// Assertion macros for the dotted line rasterizer.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef DOTTED_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DOTTED_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DLR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dotted line rasterizer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dotted line rasterizer: next-cycle check failed");

`endif

[sv/dlr_pkg.sv]
// Shared constants, types and codes for the dotted line rasterizer.
// No dependencies; imported by every module of the block.
package dlr_pkg;

  localparam int COORD_BITS  = 10;                // internal coordinate width
  localparam int FIELD_BITS  = 10;                // width of the coordinate ports
  localparam int DEC_BITS    = COORD_BITS + 3;    // signed decision term
  localparam int PERIOD_BITS = 5;
  localparam int N_LANES     = 2 ** PERIOD_BITS;  // one phase counter per period value

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(4);

  // APB register map
  localparam int APB_ADDR_BITS = 2;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] REG_DOT_PERIOD = '0;

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Step direction codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [FIELD_BITS-1:0]  field_t;
  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [1:0]             dir_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef struct packed {
    logic start;   // load a new line this cycle
    logic tick;    // advance the active line one step this cycle
  } step_ctl_t;

  typedef struct packed {
    logic busy;    // a line is active and has steps left
  } step_stat_t;

  typedef struct packed {
    field_t pix_x;
    field_t pix_y;
    logic   last;
  } step_res_t;

endpackage

[sv/dotted_line_rasterizer_core.sv]
// Dotted line rasterizer: the input register, the result register and the APB register.
// Depends on dlr_pkg, dlr_step, dlr_dot and dotted_line_rasterizer_core_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): func = FUNC_START loads start/end points and
//   returns the start pixel (always drawn); func = FUNC_TICK advances one pixel along
//   the line. A tick with no active line returns nothing.
//   Output channel (out_valid/out_stall): pix_x, pix_y, drawn and last; last marks the
//   final pixel of a line, after which ticks are dropped until the next start.
//   A start during an active line abandons it.
//   APB: register 0 at byte address 0 is dot_period (5 bits, reset 4); a step whose
//   index is a multiple of it is drawn, 0 acts as 1. Write it only between transactions.
// Timing:
//   An accepted item lands in the input register, and the result register captures the
//   step engine output when the input register advances into it.
//   One item per cycle is sustained while out_stall is low: each step is one add and
//   compare in the step engine between those two registers.
//   When out_stall is high the result register holds; the input register takes one more
//   item, and then in_stall rises until the result is taken.
//   Synchronous reset empties both registers and clears the line state.
module dotted_line_rasterizer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dlr_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [dlr_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [dlr_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  dlr_pkg::field_t                      start_x,
  input  dlr_pkg::field_t                      start_y,
  input  dlr_pkg::field_t                      end_x,
  input  dlr_pkg::field_t                      end_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dlr_pkg::field_t                      pix_x,
  output dlr_pkg::field_t                      pix_y,
  output logic                                 drawn,
  output logic                                 last
);
  import dlr_pkg::*;

  period_t    dot_period;
  logic       s1_valid, s1_func, s1_adv;
  field_t     s1_sx, s1_sy, s1_ex, s1_ey;
  step_ctl_t  ctl;
  step_stat_t stat;
  step_res_t  res;
  logic       dot_drawn;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DOT_PERIOD) ? APB_DATA_BITS'(dot_period) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_period <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_DOT_PERIOD)) begin
      dot_period <= pwdata[PERIOD_BITS-1:0];
    end
  end

  // Input register: advance whenever the result register is free
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func <= func;
      s1_sx   <= start_x;
      s1_sy   <= start_y;
      s1_ex   <= end_x;
      s1_ey   <= end_y;
    end
  end

  // Drop ticks that arrive with no active line
  assign ctl.start = s1_adv && (s1_func == FUNC_START);
  assign ctl.tick  = s1_adv && (s1_func == FUNC_TICK) && stat.busy;

  dlr_step u_step (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .start_x (s1_sx),
    .start_y (s1_sy),
    .end_x   (s1_ex),
    .end_y   (s1_ey),
    .res     (res),
    .stat    (stat)
  );

  dlr_dot u_dot (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .dot_period (dot_period),
    .drawn      (dot_drawn)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.start || ctl.tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start || ctl.tick) begin
      pix_x <= res.pix_x;
      pix_y <= res.pix_y;
      drawn <= ctl.start ? 1'b1 : dot_drawn;
      last  <= res.last;
    end
  end

  `include "dotted_line_rasterizer_core_assert.svh"

  `DLR_ASSERT_NEXT(a_start_emits_drawn, ctl.start, out_valid && drawn)
  `DLR_ASSERT_NEXT(a_idle_tick_dropped, s1_adv && (s1_func == FUNC_TICK) && !stat.busy, !out_valid)
  `DLR_ASSERT_NEXT(a_last_ends_line, ctl.tick && res.last, !stat.busy)
  `DLR_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid && out_valid)

endmodule

[sv/dlr_dot.sv]
// Dot pattern phase counters: one modulo counter per possible period value.
// Depends on dlr_pkg; driven by the step control from the top level.
module dlr_dot (
  input  logic               clk,
  input  logic               rst,
  input  dlr_pkg::step_ctl_t ctl,
  input  dlr_pkg::period_t   dot_period,
  output logic               drawn
);
  import dlr_pkg::*;

  period_t phase [N_LANES];

  // Lane p holds step_index mod p; lane 0 stays at zero, acting as period 1.
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      for (int i = 0; i < N_LANES; i++) begin
        phase[i] <= '0;
      end
    end else if (ctl.tick) begin
      for (int i = 0; i < N_LANES; i++) begin
        if (({1'b0, phase[i]} + (PERIOD_BITS+1)'(1)) >= (PERIOD_BITS+1)'(i)) begin
          phase[i] <= '0;
        end else begin
          phase[i] <= phase[i] + PERIOD_BITS'(1);
        end
      end
    end
  end

  assign drawn = (phase[dot_period] == '0);

endmodule

[sv/dlr_step.sv]
// Bresenham step engine: line state registers and the next-pixel logic.
// Depends on dlr_pkg; controlled by the top level through step_ctl_t.
module dlr_step (
  input  logic                clk,
  input  logic                rst,
  input  dlr_pkg::step_ctl_t  ctl,
  input  dlr_pkg::field_t     start_x,
  input  dlr_pkg::field_t     start_y,
  input  dlr_pkg::field_t     end_x,
  input  dlr_pkg::field_t     end_y,
  output dlr_pkg::step_res_t  res,
  output dlr_pkg::step_stat_t stat
);
  import dlr_pkg::*;

  coord_t cur_x, cur_y, major_span, minor_span, step_index;
  dec_t   decision;
  dir_t   dir_x, dir_y;
  logic   steep, busy;

  coord_t cur_x_next, cur_y_next, major_span_next, minor_span_next, step_index_next;
  dec_t   decision_next;
  dir_t   dir_x_next, dir_y_next;
  logic   steep_next, busy_next;

  coord_t x1, y1, x2, y2, dx, dy, ld_major, ld_minor, mov_x, mov_y;
  dir_t   ld_dir_x, ld_dir_y;
  logic   ld_steep;
  dec_t   ld_dec, min2, maj2;
  logic [COORD_BITS:0] step_inc;
  logic   tick_last;

  function automatic coord_t move(coord_t c, dir_t d);
    coord_t r;
    case (d)
      DIR_POS: r = c + COORD_BITS'(1);
      DIR_NEG: r = c - COORD_BITS'(1);
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic dec_t widen(coord_t v);
    return $signed({{(DEC_BITS-COORD_BITS){1'b0}}, v});
  endfunction

  // Line setup from the endpoints
  always_comb begin
    x1 = COORD_BITS'(start_x);
    y1 = COORD_BITS'(start_y);
    x2 = COORD_BITS'(end_x);
    y2 = COORD_BITS'(end_y);
    dx = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
    dy = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
    ld_dir_x = (x2 > x1) ? DIR_POS : ((x2 < x1) ? DIR_NEG : DIR_NONE);
    ld_dir_y = (y2 > y1) ? DIR_POS : ((y2 < y1) ? DIR_NEG : DIR_NONE);
    ld_steep = (dy > dx);
    ld_major = ld_steep ? dy : dx;
    ld_minor = ld_steep ? dx : dy;
    ld_dec   = (widen(ld_minor) <<< 1) - widen(ld_major);
  end

  // One step along the major axis
  always_comb begin
    mov_x     = move(cur_x, dir_x);
    mov_y     = move(cur_y, dir_y);
    min2      = widen(minor_span) <<< 1;
    maj2      = widen(major_span) <<< 1;
    step_inc  = {1'b0, step_index} + (COORD_BITS+1)'(1);
    tick_last = (step_inc >= {1'b0, major_span});
  end

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    decision_next   = decision;
    major_span_next = major_span;
    minor_span_next = minor_span;
    step_index_next = step_index;
    dir_x_next      = dir_x;
    dir_y_next      = dir_y;
    steep_next      = steep;
    busy_next       = busy;
    res.pix_x       = FIELD_BITS'(cur_x);
    res.pix_y       = FIELD_BITS'(cur_y);
    res.last        = 1'b0;
    if (ctl.start) begin
      cur_x_next      = x1;
      cur_y_next      = y1;
      decision_next   = ld_dec;
      major_span_next = ld_major;
      minor_span_next = ld_minor;
      step_index_next = '0;
      dir_x_next      = ld_dir_x;
      dir_y_next      = ld_dir_y;
      steep_next      = ld_steep;
      busy_next       = (ld_major != '0);
      res.pix_x       = FIELD_BITS'(x1);
      res.pix_y       = FIELD_BITS'(y1);
      res.last        = (ld_major == '0);
    end else if (ctl.tick) begin
      if (decision[DEC_BITS-1]) begin
        // minor coordinate holds
        if (steep) begin
          cur_y_next = mov_y;
        end else begin
          cur_x_next = mov_x;
        end
        decision_next = decision + min2;
      end else begin
        cur_x_next    = mov_x;
        cur_y_next    = mov_y;
        decision_next = decision + (min2 - maj2);
      end
      step_index_next = step_inc[COORD_BITS-1:0];
      busy_next       = !tick_last;
      res.pix_x       = FIELD_BITS'(cur_x_next);
      res.pix_y       = FIELD_BITS'(cur_y_next);
      res.last        = tick_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      decision   <= '0;
      major_span <= '0;
      minor_span <= '0;
      step_index <= '0;
      dir_x      <= DIR_NONE;
      dir_y      <= DIR_NONE;
      steep      <= 1'b0;
      busy       <= 1'b0;
    end else begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      decision   <= decision_next;
      major_span <= major_span_next;
      minor_span <= minor_span_next;
      step_index <= step_index_next;
      dir_x      <= dir_x_next;
      dir_y      <= dir_y_next;
      steep      <= steep_next;
      busy       <= busy_next;
    end
  end

  assign stat.busy = busy;

endmodule
